### hdl/stir_pkg.sv
// stir_pkg: types and codes shared by the sorted table unit, its cells and its checker
// no dependencies

package stir_pkg;

  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int POS_W    = 4;
  localparam int COUNT_W  = 5;

  typedef logic signed [VALUE_W-1:0] value_t;

  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_REMOVE = 1'b1;

  localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

  typedef struct packed {
    logic   action;
    value_t value;
  } cmd_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                has_element;
    value_t              element;
    logic [POS_W-1:0]    position;
    logic [COUNT_W-1:0]  count;
    logic                last;
  } res_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_REMOVE,
    CELL_ROTATE
  } cell_mode_t;

  typedef struct packed {
    cell_mode_t mode;
    logic       found;
  } cell_ctl_t;

endpackage

### hdl/stir_cell.sv
// stir_cell: one slot of the sorted table, shifts with its neighbors on insert,
// remove and readout rotation
// depends on stir_pkg

module stir_cell (
  input  logic                clk,
  input  stir_pkg::cell_ctl_t ctl,
  input  stir_pkg::value_t    key,
  input  logic                occ,
  input  logic                occ_right,
  input  logic                left_gt,
  input  stir_pkg::value_t    left_value,
  input  stir_pkg::value_t    right_value,
  input  stir_pkg::value_t    head_value,
  output stir_pkg::value_t    value,
  output logic                gt,
  output logic                match
);
  import stir_pkg::*;

  value_t value_next;

  assign gt    = !occ || (value > key);
  assign match = occ && (value == key);

  always_comb begin
    value_next = value;
    case (ctl.mode)
      CELL_INSERT: begin
        if (gt) begin
          value_next = left_gt ? left_value : key;
        end
      end
      CELL_REMOVE: begin
        if (ctl.found && occ && (value >= key)) begin
          value_next = right_value;
        end
      end
      CELL_ROTATE: begin
        if (occ) begin
          value_next = occ_right ? right_value : head_value;
        end
      end
      default: begin
        value_next = value;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    value <= value_next;
  end

endmodule

### hdl/sorted_table_insert_remove_unit.sv
// sorted_table_insert_remove_unit: bounded ascending table of signed values
// built as a row of stir_cell slots; depends on stir_pkg and stir_cell
//
// Usage:
//   cmd channel (cmd_valid / cmd_stall / cmd): one request inserts or removes
//   a value. An insert lands after any equal entries; a remove deletes one
//   equal entry and closes the gap.
//   res channel (res_valid / res_stall / res): after each request the whole
//   table is read out in ascending order, one result per entry, with status,
//   position, count and last. An empty table gives one result with no element.
//   Latency: the first result is valid the cycle after the request is taken.
//   A new request waits until the readout of the previous one is done, which
//   rotates the occupied cells by one slot per result taken.
//   cmd_stall is high while results are pending. When the receiver stalls,
//   the cells hold and the result stays unchanged.
//   Reset empties the table; entries above the count are never read.

module sorted_table_insert_remove_unit #(
  parameter int DEPTH = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  output logic           cmd_stall,
  input  stir_pkg::cmd_t cmd,
  output logic           res_valid,
  input  logic           res_stall,
  output stir_pkg::res_t res
);
  import stir_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = $clog2(DEPTH);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EMIT = 2'b10
  } state_t;

  state_t          state;
  logic [CW-1:0]   count;
  logic [CW-1:0]   count_next;
  logic [PW-1:0]   pos;
  logic [STATUS_W-1:0] status;
  logic [STATUS_W-1:0] status_next;

  cell_ctl_t       ctl;
  value_t          cell_value [DEPTH];
  logic [DEPTH-1:0] cell_gt;
  logic [DEPTH-1:0] cell_match;
  logic [DEPTH-1:0] occ;

  logic cmd_accept;
  logic res_accept;
  logic full;
  logic empty;
  logic found;
  logic last;

  assign cmd_stall  = (state != S_IDLE);
  assign res_valid  = (state == S_EMIT);
  assign cmd_accept = cmd_valid && !cmd_stall;
  assign res_accept = res_valid && !res_stall;
  assign full       = (count == CW'(DEPTH));
  assign empty      = (count == '0);
  assign found      = |cell_match;
  assign last       = empty || ((CW'(pos) + CW'(1)) == count);

  always_comb begin
    ctl.mode    = CELL_HOLD;
    ctl.found   = found;
    count_next  = count;
    status_next = status;
    if (cmd_accept) begin
      status_next = ST_DONE;
      case (cmd.action)
        ACT_INSERT: begin
          if (full) begin
            status_next = ST_FULL;
          end else begin
            ctl.mode   = CELL_INSERT;
            count_next = count + CW'(1);
          end
        end
        ACT_REMOVE: begin
          if (empty) begin
            status_next = ST_EMPTY;
          end else if (!found) begin
            status_next = ST_NOT_FOUND;
          end else begin
            ctl.mode   = CELL_REMOVE;
            count_next = count - CW'(1);
          end
        end
        default: begin
          status_next = ST_DONE;
        end
      endcase
    end else if (res_accept && !empty) begin
      ctl.mode = CELL_ROTATE;
    end
  end

  genvar i;
  generate
    for (i = 0; i < DEPTH; i++) begin : g_cell
      logic   left_gt;
      value_t left_value;
      value_t right_value;
      logic   occ_right;

      assign occ[i] = (CW'(i) < count);

      if (i == 0) begin : g_head
        assign left_gt    = 1'b0;
        assign left_value = cell_value[0];
      end else begin : g_body
        assign left_gt    = cell_gt[i-1];
        assign left_value = cell_value[i-1];
      end

      if (i == DEPTH - 1) begin : g_tail
        assign right_value = cell_value[i];
        assign occ_right   = 1'b0;
      end else begin : g_inner
        assign right_value = cell_value[i+1];
        assign occ_right   = occ[i+1];
      end

      stir_cell u_cell (
        .clk         (clk),
        .ctl         (ctl),
        .key         (cmd.value),
        .occ         (occ[i]),
        .occ_right   (occ_right),
        .left_gt     (left_gt),
        .left_value  (left_value),
        .right_value (right_value),
        .head_value  (cell_value[0]),
        .value       (cell_value[i]),
        .gt          (cell_gt[i]),
        .match       (cell_match[i])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      count <= count_next;
      case (state)
        S_IDLE: begin
          if (cmd_accept) begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (res_accept && last) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    status <= status_next;
    if (cmd_accept) begin
      pos <= '0;
    end else if (res_accept) begin
      pos <= pos + PW'(1);
    end
  end

  always_comb begin
    res.status      = status;
    res.has_element = !empty;
    res.element     = empty ? value_t'(0) : cell_value[0];
    res.position    = empty ? '0 : POS_W'(pos);
    res.count       = COUNT_W'(count);
    res.last        = last;
  end

endmodule

### hdl/stir_chk.sv
// stir_chk: port-level checks for the sorted table unit, bound to the top level
// depends on stir_pkg and sorted_table_insert_remove_unit

module stir_chk (
  input logic           clk,
  input logic           rst,
  input logic           cmd_valid,
  input logic           cmd_stall,
  input stir_pkg::cmd_t cmd,
  input logic           res_valid,
  input logic           res_stall,
  input stir_pkg::res_t res
);
  import stir_pkg::*;

  // a taken request starts its readout in the next cycle
  a_cmd_to_res: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && !cmd_stall |=> res_valid)
    else $error("no result after request");

  // no new request while results are pending
  a_busy_stall: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> cmd_stall)
    else $error("request taken during readout");

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(res))
    else $error("stalled result changed");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_stall && res.last |=> !res_valid)
    else $error("result after last");

  a_empty_shape: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res.has_element |-> res.last && (res.count == '0))
    else $error("bad empty-table result");

endmodule

bind sorted_table_insert_remove_unit stir_chk u_stir_chk (
  .clk       (clk),
  .rst       (rst),
  .cmd_valid (cmd_valid),
  .cmd_stall (cmd_stall),
  .cmd       (cmd),
  .res_valid (res_valid),
  .res_stall (res_stall),
  .res       (res)
);

### dv/testbench.sv
// testbench for sorted_table_insert_remove_unit: directed and random insert/remove requests
// checked against an in-bench model of the sorted table, results compared field by field
// depends on stir_pkg and the unit rtl
`timescale 1ns / 1ps

module testbench;
  import stir_pkg::*;

  localparam int TABLE_DEPTH = 16;
  localparam int CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cmd_valid = 1'b0;
  logic cmd_stall;
  cmd_t cmd = '0;
  logic res_valid;
  logic res_stall = 1'b0;
  res_t res;

  value_t table_entries[TABLE_DEPTH];
  int     table_count = 0;
  res_t   expected_rows[$];
  int     errors = 0;
  int     cycle_count = 0;
  int     sender_idle_pct = 28;
  int     receiver_idle_pct = 60;

  sorted_table_insert_remove_unit #(.DEPTH(TABLE_DEPTH)) dut (
    .clk(clk),
    .rst(rst),
    .cmd_valid(cmd_valid),
    .cmd_stall(cmd_stall),
    .cmd(cmd),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .res(res)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      res_stall <= 1'b0;
    end else begin
      res_stall <= ($urandom_range(99) < receiver_idle_pct);
    end
  end

  // table model, updated when a request is taken
  function automatic void predict_table_action(input cmd_t c);
    logic [STATUS_W-1:0] status;
    int p;
    int hit;
    res_t row;
    status = ST_DONE;
    if (c.action == ACT_INSERT) begin
      if (table_count >= TABLE_DEPTH) begin
        status = ST_FULL;
      end else begin
        p = table_count;
        while (p > 0 && table_entries[p-1] > c.value) begin
          table_entries[p] = table_entries[p-1];
          p--;
        end
        table_entries[p] = c.value;
        table_count++;
      end
    end else if (table_count == 0) begin
      status = ST_EMPTY;
    end else begin
      hit = -1;
      for (int i = 0; i < table_count; i++) begin
        if (hit < 0 && table_entries[i] == c.value) hit = i;
      end
      if (hit < 0) begin
        status = ST_NOT_FOUND;
      end else begin
        for (int i = hit; i + 1 < table_count; i++) table_entries[i] = table_entries[i+1];
        table_count--;
      end
    end
    if (table_count == 0) begin
      row = '0;
      row.status = status;
      row.last = 1'b1;
      expected_rows.push_back(row);
    end else begin
      for (int i = 0; i < table_count; i++) begin
        row.status = status;
        row.has_element = 1'b1;
        row.element = table_entries[i];
        row.position = POS_W'(i);
        row.count = COUNT_W'(table_count);
        row.last = (i + 1 == table_count);
        expected_rows.push_back(row);
      end
    end
  endfunction

  task automatic field_mismatch(input string name, input logic [31:0] want_v,
                                input logic [31:0] got_v);
    $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want_v, got_v);
    errors++;
  endtask

  always @(posedge clk) begin
    res_t want;
    if (!rst && res_valid && !res_stall) begin
      if (expected_rows.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, res);
        errors++;
      end else begin
        want = expected_rows.pop_front();
        if (res.status !== want.status) field_mismatch("status", want.status, res.status);
        if (res.has_element !== want.has_element)
          field_mismatch("has_element", want.has_element, res.has_element);
        if (res.element !== want.element) field_mismatch("element", want.element, res.element);
        if (res.position !== want.position)
          field_mismatch("position", want.position, res.position);
        if (res.count !== want.count) field_mismatch("count", want.count, res.count);
        if (res.last !== want.last) field_mismatch("last", want.last, res.last);
      end
    end
  end

  task automatic send_request(input logic action, input value_t v);
    cmd_t c;
    int gap;
    c.action = action;
    c.value = v;
    if ($urandom_range(99) < sender_idle_pct) begin
      cmd_valid <= 1'b0;
      gap = $urandom_range(1, 4);
      repeat (gap) @(posedge clk);
    end
    cmd_valid <= 1'b1;
    cmd <= c;
    @(posedge clk);
    while (cmd_stall) @(posedge clk);
    predict_table_action(c);
  endtask

  task automatic wait_for_results();
    cmd_valid <= 1'b0;
    while (expected_rows.size() != 0) @(posedge clk);
  endtask

  function automatic value_t random_value();
    case ($urandom_range(9))
      0, 1, 2, 3: return value_t'($urandom_range(8)) - 4;
      4: begin
        case ($urandom_range(3))
          0: return 32'sh8000_0000;
          1: return 32'sh7fff_ffff;
          2: return '0;
          default: return '1;
        endcase
      end
      default: return value_t'($urandom);
    endcase
  endfunction

  task automatic test_remove_from_empty();
    send_request(ACT_REMOVE, 0);
  endtask

  task automatic test_extreme_values();
    send_request(ACT_INSERT, 32'sh7fff_ffff);
    send_request(ACT_INSERT, 32'sh8000_0000);
    send_request(ACT_INSERT, 0);
    send_request(ACT_INSERT, -1);
    send_request(ACT_REMOVE, 32'sh7fff_ffff);
    send_request(ACT_REMOVE, 32'sh8000_0000);
  endtask

  task automatic test_duplicate_entries();
    send_request(ACT_INSERT, 5);
    send_request(ACT_INSERT, 5);
    send_request(ACT_INSERT, 5);
    send_request(ACT_REMOVE, 5);
    send_request(ACT_REMOVE, 7);
  endtask

  task automatic test_full_table();
    int k;
    k = 0;
    while (table_count < TABLE_DEPTH) begin
      send_request(ACT_INSERT, value_t'((k * 37) % 23) - 11);
      k++;
    end
    send_request(ACT_INSERT, 3);
    send_request(ACT_REMOVE, 12345);
  endtask

  // alternating fill and drain runs so the table often reaches full and empty
  task automatic test_random_mix(input int n_items);
    bit filling;
    int run_left;
    logic action;
    value_t v;
    filling = 1'b0;
    run_left = 0;
    for (int i = 0; i < n_items; i++) begin
      if (run_left == 0) begin
        filling = ~filling;
        run_left = $urandom_range(5, 30);
      end
      run_left--;
      action = ($urandom_range(99) < (filling ? 80 : 20)) ? ACT_INSERT : ACT_REMOVE;
      if (action == ACT_REMOVE && table_count > 0 && $urandom_range(99) < 75) begin
        v = table_entries[$urandom_range(table_count - 1)];
      end else begin
        v = random_value();
      end
      send_request(action, v);
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_remove_from_empty();
    test_extreme_values();
    test_duplicate_entries();
    test_full_table();
    test_random_mix(150);
    wait_for_results();
    sender_idle_pct = 60;
    receiver_idle_pct = 28;
    test_random_mix(150);
    wait_for_results();
    sender_idle_pct = 0;
    receiver_idle_pct = 0;
    test_random_mix(150);
    wait_for_results();
    repeat (TABLE_DEPTH + 4) @(posedge clk);
    if (errors == 0 && expected_rows.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
